>>> sv/fdss_pkg.sv
// Package for the floppy drive select, step and status block.
// Holds drive counts, pin positions, mode codes and the result item type.
// No dependencies.
package fdss_pkg;

   localparam int DRIVE_COUNT = 4;      // drives that exist, 1..4
   localparam int MAX_DRIVES  = 4;      // drives the select lines can name
   localparam int TRACK_W     = 7;
   localparam logic [TRACK_W-1:0] LAST_TRACK = TRACK_W'(79);

   // Request modes.
   localparam logic [2:0] MODE_CTRL_WRITE = 3'd0;
   localparam logic [2:0] MODE_STATUS     = 3'd1;
   localparam logic [2:0] MODE_INSERT     = 3'd2;
   localparam logic [2:0] MODE_EJECT      = 3'd3;
   localparam logic [2:0] MODE_SOFT_RESET = 3'd4;

   // Control byte pins, all active low.
   localparam int PIN_MOTOR = 7;
   localparam int PIN_SEL0  = 3;
   localparam int PIN_SIDE  = 2;
   localparam int PIN_DIR   = 1;
   localparam int PIN_STEP  = 0;

   // Status byte pins, active low except ST_CHANGE, which is active high.
   localparam int ST_READY   = 5;
   localparam int ST_TRACK0  = 4;
   localparam int ST_PROTECT = 3;
   localparam int ST_CHANGE  = 2;

   typedef struct packed {
      logic [1:0] selected_unit;
      logic       selected_valid;
      logic       head_side;
      logic       motor_running;
      logic [7:0] status_byte;
   } rsp_item_type;

endpackage

>>> sv/fdss_core.sv
// Drive state registers and the per-item update and status logic.
// Depends on fdss_pkg.
module fdss_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [2:0]           mode,
   input  logic [7:0]           port_value,
   input  logic [1:0]           drive_unit,
   input  logic                 protect_flag,
   output fdss_pkg::rsp_item_type result
);
   import fdss_pkg::*;

   logic [7:0]         prev_port_ff, prev_port_in;
   logic               sel_valid_ff, sel_valid_in;
   logic [1:0]         sel_unit_ff, sel_unit_in;
   logic               motor_ff, motor_in;
   logic               side_ff, side_in;
   logic [TRACK_W-1:0] track_ff [MAX_DRIVES];
   logic [TRACK_W-1:0] track_in [MAX_DRIVES];
   logic [MAX_DRIVES-1:0] present_ff, present_in;
   logic [MAX_DRIVES-1:0] protect_ff, protect_in;
   logic [MAX_DRIVES-1:0] change_ff, change_in;

   logic [7:0]         falling;
   logic               found;
   logic [1:0]         found_unit;
   logic [TRACK_W-1:0] cur_track;
   logic [TRACK_W-1:0] step_track;
   logic               unit_ok;

   always_comb begin
      falling = prev_port_ff & ~port_value;
      found = 1'b0;
      found_unit = 2'd0;
      for (int u = DRIVE_COUNT - 1; u >= 0; u--) begin
         if (!port_value[PIN_SEL0 + u]) begin
            found = 1'b1;
            found_unit = 2'(u);
         end
      end
      cur_track = track_ff[found_unit];
      if (port_value[PIN_DIR]) begin
         step_track = (cur_track == '0) ? '0 : cur_track - TRACK_W'(1);
      end else begin
         step_track = (cur_track >= LAST_TRACK) ? LAST_TRACK : cur_track + TRACK_W'(1);
      end
      unit_ok = ({1'b0, drive_unit} < 3'(DRIVE_COUNT));
   end

   always_comb begin
      prev_port_in = prev_port_ff;
      sel_valid_in = sel_valid_ff;
      sel_unit_in  = sel_unit_ff;
      motor_in     = motor_ff;
      side_in      = side_ff;
      track_in     = track_ff;
      present_in   = present_ff;
      protect_in   = protect_ff;
      change_in    = change_ff;
      case (mode)
         MODE_CTRL_WRITE: begin
            if (falling[PIN_SEL0 +: MAX_DRIVES] != '0) begin
               motor_in = ~port_value[PIN_MOTOR];
            end
            if (falling[PIN_STEP] && found) begin
               track_in[found_unit] = step_track;
               if (present_ff[found_unit]) begin
                  change_in[found_unit] = 1'b1;
               end
            end
            sel_valid_in = found;
            sel_unit_in  = found_unit;
            side_in      = ~port_value[PIN_SIDE];
            prev_port_in = port_value;
         end
         MODE_INSERT: begin
            if (unit_ok) begin
               present_in[drive_unit] = 1'b1;
               protect_in[drive_unit] = protect_flag;
               change_in[drive_unit]  = 1'b0;
            end
         end
         MODE_EJECT: begin
            if (unit_ok) begin
               present_in[drive_unit] = 1'b0;
               change_in[drive_unit]  = 1'b0;
            end
         end
         MODE_SOFT_RESET: begin
            prev_port_in = 8'hFF;
            sel_valid_in = 1'b0;
            sel_unit_in  = 2'd0;
            motor_in     = 1'b0;
            side_in      = 1'b0;
            change_in    = '0;
            for (int u = 0; u < MAX_DRIVES; u++) begin
               track_in[u] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // The result reflects the state after this item's effect.
   always_comb begin
      result.status_byte = 8'hFF;
      if (sel_valid_in) begin
         result.status_byte[ST_READY]   = ~(motor_in && present_in[sel_unit_in]);
         result.status_byte[ST_TRACK0]  = ~(track_in[sel_unit_in] == '0);
         result.status_byte[ST_PROTECT] = ~(present_in[sel_unit_in] &&
                                            protect_in[sel_unit_in]);
         result.status_byte[ST_CHANGE]  = change_in[sel_unit_in];
      end
      result.motor_running  = motor_in;
      result.head_side      = side_in;
      result.selected_valid = sel_valid_in;
      result.selected_unit  = sel_unit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_port_ff <= 8'hFF;
         sel_valid_ff <= 1'b0;
         sel_unit_ff  <= 2'd0;
         motor_ff     <= 1'b0;
         side_ff      <= 1'b0;
         present_ff   <= '0;
         protect_ff   <= '0;
         change_ff    <= '0;
         for (int u = 0; u < MAX_DRIVES; u++) begin
            track_ff[u] <= '0;
         end
      end else if (accept) begin
         prev_port_ff <= prev_port_in;
         sel_valid_ff <= sel_valid_in;
         sel_unit_ff  <= sel_unit_in;
         motor_ff     <= motor_in;
         side_ff      <= side_in;
         present_ff   <= present_in;
         protect_ff   <= protect_in;
         change_ff    <= change_in;
         track_ff     <= track_in;
      end
   end

endmodule

>>> sv/fdss_out_buf.sv
// Result register with a skid stage so the input side keeps flowing.
// Depends on fdss_pkg.
module fdss_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fdss_pkg::rsp_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fdss_pkg::rsp_item_type out_item
);
   import fdss_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         in_fire;
   logic         out_fire;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;
   assign in_fire   = in_valid & in_ready;
   assign out_fire  = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_in       = in_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_item;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> sv/floppy_drive_select_step_status.sv
// Floppy drive select, step and status block, top level.
// Each accepted request's response item is registered. Throughput: one item
// per cycle while the skid stage is empty; drive state and the response
// register update in the same cycle, and a skid stage absorbs one stall.
// Reset (synchronous, active high) clears all drive state, disks included,
// and empties the response buffer.
module floppy_drive_select_step_status (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] port_value, [9:8] drive_unit,
                                    // [10] protect_flag, [15:11] zero
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] status_byte, [8] motor_running,
                                    // [9] head_side, [10] selected_valid,
                                    // [12:11] selected_unit, [15:13] zero
);
   import fdss_pkg::*;

   logic         req_fire;
   rsp_item_type core_result;
   rsp_item_type buf_item;

   // An item changes drive state only when it is actually taken.
   assign req_fire = req_tvalid & req_tready;

   fdss_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_fire),
      .mode         (req_tuser),
      .port_value   (req_tdata[7:0]),
      .drive_unit   (req_tdata[9:8]),
      .protect_flag (req_tdata[10]),
      .result       (core_result)
   );

   // The response buffer holds each item's status until the sink takes it.
   fdss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (buf_item)
   );

   assign rsp_tdata = {3'b000, buf_item};

endmodule
